/* rtl/core/rrts_pkg.sv */
// Package with constants and types of the round-robin thread scheduler.
`default_nettype none
package rrts_pkg;
  localparam int unsigned MaxThreads = 16;
  localparam int unsigned SlotW = $clog2(MaxThreads);
  localparam int unsigned CntW = $clog2(MaxThreads + 1);

  typedef enum logic [3:0] {
    CMD_CREATE = 4'd0, CMD_SUSPEND = 4'd1, CMD_RESUME = 4'd2, CMD_TERMINATE = 4'd3,
    CMD_GET_EXIT = 4'd4, CMD_WAIT = 4'd5, CMD_TICK = 4'd6, CMD_YIELD = 4'd7,
    CMD_SWITCH = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_UNUSED = 3'd0, ST_READY = 3'd1, ST_RUNNING = 3'd2, ST_SUSPENDED = 3'd3,
    ST_WAITING = 3'd4, ST_TERMINATED = 3'd5
  } slot_st_e;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatTimeout = 2'd1;
  localparam logic [1:0] StatInvalid = 2'd2;

  localparam logic [31:0] ResStillActive = 32'd259;
  localparam logic [31:0] ResTimeout = 32'd258;
  localparam logic [31:0] ResInvalid = 32'hFFFF_FFFF;
  localparam logic [31:0] SliceReset = 32'd1000;

  localparam logic [1:0] AddrPreempt = 2'd0;
  localparam logic [1:0] AddrSlice = 2'd1;
endpackage
`default_nettype wire

/* rtl/core/round_robin_thread_scheduler.sv */
// Top level of the round-robin thread scheduler with its slot memory.
// A command walks the slot memory only when it needs to: a reschedule reads the slots in turn,
// terminating another slot runs a wakeup sweep, and terminating the current one runs a scan,
// a reschedule if another slot is live, and a wakeup; one read port sets the sweeps.
// busy is high from the accepting edge until done; the next command is accepted at the edge
// ending the done strobe, so no command is taken while one is in flight. Reset: slot 0 running,
// others unused, then a clearing pass of the slot memory with busy high.
`default_nettype none
module round_robin_thread_scheduler import rrts_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  input  wire logic [3:0]  command_i,
  input  wire logic [7:0]  thread_slot_i,
  input  wire logic [31:0] exit_value_i,
  input  wire logic [31:0] wait_timeout_i,
  input  wire logic        start_suspended_i,
  output logic [1:0]       status_o,
  output logic [31:0]      result_value_o,
  output logic [3:0]       running_slot_o,
  output logic             switched_o,
  output logic             slice_expired_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // Slot record: state, suspend count, wait target.
  typedef struct packed {
    slot_st_e          st;
    logic [7:0]        cnt;
    logic [SlotW-1:0]  tgt;
  } slot_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_EXEC, S_SCAN_RD, S_SCAN, S_RESCHED_RD, S_RESCHED,
    S_WAKE_RD, S_WAKE, S_FINISH
  } fsm_e;

  slot_t            mem_q [MaxThreads];
  logic [31:0]      exit_mem_q [MaxThreads];
  slot_t            rd_q;
  logic [31:0]      exit_rd_q;
  logic [SlotW-1:0] raddr;
  logic             we;
  logic [SlotW-1:0] waddr;
  slot_t            wdata;
  logic             exit_we;

  fsm_e             state_q;
  logic [SlotW-1:0] idx_q;
  logic [SlotW:0]   step_q;
  logic [CntW-1:0]  in_use_q;
  logic [SlotW-1:0] cur_q, before_q, tslot_q;
  logic [31:0]      slice_cnt_q, slice_len_q;
  logic             preempt_q;
  cmd_e             cmd_q;
  logic [31:0]      exitv_q;
  logic             tmo_nz_q, other_q, wake_q;
  logic [1:0]       status_q;
  logic [31:0]      result_q;
  logic             expired_q, done_q, switched_q;
  slot_st_e         cur_st_q;

  logic valid_slot;
  assign valid_slot = (thread_slot_i < 8'(MaxThreads)) &&
                      (thread_slot_i[SlotW-1:0] < in_use_q[SlotW-1:0] ||
                       in_use_q == CntW'(MaxThreads));

  // Memory: one read port with registered data, one write port.
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[raddr];
    exit_rd_q <= exit_mem_q[raddr];
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (exit_we) begin
      exit_mem_q[waddr] <= exitv_q;
    end
  end

  logic [SlotW-1:0] nxt_idx;
  assign nxt_idx = idx_q + SlotW'(1);

  always_comb begin
    raddr = idx_q;
    we = 1'b0;
    exit_we = 1'b0;
    waddr = idx_q;
    wdata = rd_q;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '{st: (idx_q == '0) ? ST_RUNNING : ST_UNUSED, cnt: 8'd0, tgt: '0};
      end
      S_IDLE: raddr = thread_slot_i[SlotW-1:0];
      S_RD: raddr = tslot_q;
      S_EXEC: begin
        waddr = tslot_q;
        raddr = cur_q;
        case (cmd_q)
          CMD_CREATE: begin
            we = in_use_q != CntW'(MaxThreads);
            waddr = in_use_q[SlotW-1:0];
            wdata = '{st: exitv_q[0] ? ST_SUSPENDED : ST_READY,
                      cnt: {7'd0, exitv_q[0]}, tgt: '0};
          end
          CMD_SUSPEND: if (status_q == StatOk) begin
            we = 1'b1;
            if (rd_q.cnt != 8'hFF) wdata.cnt = rd_q.cnt + 8'd1;
            if (rd_q.st == ST_RUNNING || rd_q.st == ST_READY) wdata.st = ST_SUSPENDED;
          end
          CMD_RESUME: if (status_q == StatOk && rd_q.cnt != 8'd0) begin
            we = 1'b1;
            wdata.cnt = rd_q.cnt - 8'd1;
            if (rd_q.cnt == 8'd1 && rd_q.st == ST_SUSPENDED) wdata.st = ST_READY;
          end
          CMD_TERMINATE: if (status_q == StatOk) begin
            we = 1'b1;
            exit_we = 1'b1;
            wdata.st = ST_TERMINATED;
          end
          CMD_WAIT: if (status_q == StatOk && rd_q.st != ST_TERMINATED && tmo_nz_q) begin
            // The current slot's record is written in step 0 of the reschedule below.
            we = 1'b0;
          end
          default: ;
        endcase
      end
      S_SCAN_RD, S_WAKE_RD: raddr = idx_q;
      S_SCAN: raddr = nxt_idx;
      S_RESCHED_RD: raddr = cur_q;
      S_RESCHED: begin
        raddr = nxt_idx;
        // Step 0 handles the current slot; later steps look for a ready slot, the last falls back.
        if (step_q == '0) begin
          we = 1'b1;
          waddr = cur_q;
          if (cmd_q == CMD_SWITCH) raddr = tslot_q;
          // A wait reaches the reschedule only when the current slot has to wait.
          if (cmd_q == CMD_WAIT) begin
            wdata.st = ST_WAITING;
            wdata.tgt = tslot_q;
          end else if (rd_q.st == ST_RUNNING) begin
            wdata.st = ST_READY;
          end
        end else if (rd_q.st == ST_READY) begin
          we = 1'b1;
          wdata.st = ST_RUNNING;
        end else if (step_q == (SlotW+1)'(MaxThreads)) begin
          we = 1'b1;
          if (cur_st_q == ST_READY || cur_st_q == ST_WAITING) begin
            wdata.st = ST_RUNNING;
            wdata.tgt = '0;
          end
        end
      end
      S_WAKE: begin
        raddr = nxt_idx;
        if (rd_q.st == ST_WAITING && rd_q.tgt == tslot_q) begin
          we = 1'b1;
          wdata.st = ST_READY;
          wdata.tgt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q <= '0;
      step_q <= '0;
      in_use_q <= CntW'(1);
      cur_q <= '0;
      before_q <= '0;
      slice_cnt_q <= '0;
      slice_len_q <= SliceReset;
      preempt_q <= 1'b0;
      done_q <= 1'b0;
      cmd_q <= CMD_CREATE;
      tslot_q <= '0;
      exitv_q <= '0;
      tmo_nz_q <= 1'b0;
      status_q <= StatOk;
      result_q <= '0;
      expired_q <= 1'b0;
      other_q <= 1'b0;
      wake_q <= 1'b0;
      cur_st_q <= ST_UNUSED;
      switched_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr[2] == AddrPreempt[0]) preempt_q <= pwdata[0];
        if (paddr[2] == AddrSlice[0]) slice_len_q <= pwdata;
      end
      case (state_q)
        S_CLEAR: begin
          idx_q <= nxt_idx;
          if (idx_q == SlotW'(MaxThreads - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (start) begin
          cmd_q <= cmd_e'(command_i);
          tslot_q <= thread_slot_i[SlotW-1:0];
          exitv_q <= (command_i == CMD_CREATE) ? {31'd0, start_suspended_i} : exit_value_i;
          tmo_nz_q <= wait_timeout_i != '0;
          before_q <= cur_q;
          status_q <= StatOk;
          result_q <= '0;
          expired_q <= 1'b0;
          wake_q <= 1'b0;
          if ((command_i >= CMD_SUSPEND && command_i <= CMD_GET_EXIT) ||
              command_i == CMD_WAIT || command_i == CMD_SWITCH) begin
            if (!valid_slot) begin
              status_q <= StatInvalid;
              result_q <= ResInvalid;
            end
          end
          state_q <= S_RD;
        end
        S_RD: state_q <= S_EXEC;
        S_EXEC: begin
          state_q <= S_FINISH;
          case (cmd_q)
            CMD_CREATE: begin
              if (in_use_q == CntW'(MaxThreads)) begin
                status_q <= StatInvalid;
                result_q <= ResInvalid;
              end else begin
                result_q <= 32'(in_use_q);
                in_use_q <= in_use_q + CntW'(1);
              end
            end
            CMD_TERMINATE: if (status_q == StatOk) begin
              wake_q <= 1'b1;
              other_q <= 1'b0;
              if (tslot_q == cur_q) begin
                idx_q <= '0;
                state_q <= S_SCAN_RD;
              end else begin
                idx_q <= '0;
                state_q <= S_WAKE_RD;
              end
            end
            CMD_GET_EXIT: if (status_q == StatOk) begin
              result_q <= (rd_q.st == ST_TERMINATED) ? exit_rd_q : ResStillActive;
            end
            CMD_WAIT: if (status_q == StatOk && rd_q.st != ST_TERMINATED) begin
              if (!tmo_nz_q) begin
                status_q <= StatTimeout;
                result_q <= ResTimeout;
              end else begin
                state_q <= S_RESCHED_RD;
              end
            end
            CMD_TICK: if (preempt_q) begin
              if ((slice_cnt_q != '1 ? slice_cnt_q + 32'd1 : slice_cnt_q) >= slice_len_q)
              begin
                expired_q <= 1'b1;
                state_q <= S_RESCHED_RD;
              end
              if (slice_cnt_q != '1) slice_cnt_q <= slice_cnt_q + 32'd1;
            end
            CMD_YIELD: state_q <= S_RESCHED_RD;
            CMD_SWITCH: if (status_q == StatOk && tslot_q != cur_q &&
                            (rd_q.st == ST_READY || rd_q.st == ST_RUNNING)) begin
              state_q <= S_RESCHED_RD;
            end
            default: ;
          endcase
        end
        S_SCAN_RD: state_q <= S_SCAN;
        S_SCAN: begin
          if (idx_q != cur_q && (rd_q.st == ST_READY || rd_q.st == ST_RUNNING))
            other_q <= 1'b1;
          idx_q <= nxt_idx;
          if (idx_q == SlotW'(MaxThreads - 1)) begin
            idx_q <= '0;
            state_q <= (other_q || (idx_q != cur_q && (rd_q.st == ST_READY ||
                        rd_q.st == ST_RUNNING))) ? S_RESCHED_RD : S_WAKE_RD;
          end
        end
        S_RESCHED_RD: begin
          idx_q <= cur_q;
          step_q <= '0;
          state_q <= S_RESCHED;
        end
        S_RESCHED: begin
          idx_q <= nxt_idx;
          step_q <= step_q + (SlotW+1)'(1);
          if (step_q == '0) begin
            cur_st_q <= wdata.st;
            if (cmd_q == CMD_SWITCH) begin
              // Named switch: skip the walk and go to the target directly.
              idx_q <= tslot_q;
              step_q <= (SlotW+1)'(1);
            end
          end else if (rd_q.st == ST_READY || step_q == (SlotW+1)'(MaxThreads)) begin
            if (rd_q.st == ST_READY && step_q != (SlotW+1)'(MaxThreads)) begin
              cur_q <= idx_q;
              slice_cnt_q <= '0;
            end
            idx_q <= '0;
            state_q <= wake_q ? S_WAKE_RD : S_FINISH;
          end else if (cmd_q == CMD_SWITCH) begin
            state_q <= S_FINISH;
          end
        end
        S_WAKE_RD: state_q <= S_WAKE;
        S_WAKE: begin
          idx_q <= nxt_idx;
          if (idx_q == SlotW'(MaxThreads - 1)) state_q <= S_FINISH;
        end
        S_FINISH: begin
          done_q <= 1'b1;
          switched_q <= cur_q != before_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = state_q != S_IDLE;
  assign done = done_q;
  assign status_o = status_q;
  assign result_value_o = result_q;
  assign running_slot_o = 4'(cur_q);
  assign switched_o = switched_q;
  assign slice_expired_o = expired_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == AddrPreempt[0]) ? {31'd0, preempt_q} :
                  (paddr[2] == AddrSlice[0]) ? slice_len_q : 32'd0;
endmodule
`default_nettype wire

/* rtl/core/rrts_checker.sv */
// Port-level checker for the round-robin thread scheduler and its bind.
`default_nettype none
module rrts_props import rrts_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status_o,
  input wire logic       switched_o,
  input wire logic       slice_expired_o,
  input wire logic       pready
);
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(busy)) else $error("done without busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("done longer than one cycle");
  a_invalid_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && status_o == StatInvalid |-> !switched_o) else $error("switch on invalid slot");
  a_expired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && slice_expired_o |-> status_o == StatOk) else $error("expiry with bad status");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");
endmodule

bind round_robin_thread_scheduler rrts_props u_rrts_props (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done(done),
  .status_o(status_o), .switched_o(switched_o), .slice_expired_o(slice_expired_o),
  .pready(pready)
);
`default_nettype wire
